/* hw/rtl/b64lw_pkg.sv */
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, constants and the sextet-to-character map for the base64
// encoder with line wrap.
// ----------------------------------------------------------------------------
`default_nettype none

package b64lw_pkg;

  // depth of the small queues (front to back, back to result side)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // characters
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_NL      = 8'h0A;

  // configuration register indexes
  localparam logic [1:0] CFG_URL   = 2'd0;
  localparam logic [1:0] CFG_PAD   = 2'd1;
  localparam logic [1:0] CFG_WIDTH = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       run_last;
    logic       message_end;
  } out_t;

  typedef struct packed {
    logic       url_alphabet;
    logic       pad_enable;
    logic [7:0] line_width;
  } cfg_t;

  // one request's line characters, handed from front to back
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;  // index of the final character
    logic            last;      // request closes the message
  } op_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CH_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CH_LOWER_A + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = CH_ZERO + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = url ? CH_DASH : CH_PLUS;
    end else begin
      c = url ? CH_UNDER : CH_SLASH;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/b64lw_front.sv */
// ----------------------------------------------------------------------------
// b64lw_front
// Takes bytes, tracks group phase and leftover bits, builds the line
// characters of each request (flush and padding included) and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module b64lw_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire b64lw_pkg::cfg_t cfg,
  input  wire logic           push,
  output logic                full,
  input  wire b64lw_pkg::in_t item,
  output logic                op_valid,
  output b64lw_pkg::op_t      op_head,
  input  wire logic           op_pop
);
  import b64lw_pkg::*;

  logic [1:0]        byte_phase;
  logic [3:0]        leftover_bits;
  logic [1:0]        byte_phase_next;
  logic [3:0]        leftover_bits_next;
  op_t               op_new;
  logic [5:0]        s0, s1;
  logic [2:0]        n_chars;
  logic              accept;

  op_t               q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign op_valid = (count != '0);
  assign op_head  = q[rd_ptr];
  assign accept   = push && !full;

  always_comb begin
    s0 = '0;
    s1 = '0;
    n_chars = 3'd1;
    byte_phase_next = 2'd1;
    leftover_bits_next = {2'b00, item.data_byte[1:0]};
    unique case (byte_phase)
      2'd1: begin
        s0 = {leftover_bits[1:0], item.data_byte[7:4]};
        s1 = {item.data_byte[3:0], 2'b00};
        leftover_bits_next = item.data_byte[3:0];
        byte_phase_next = 2'd2;
        if (item.end_of_message) n_chars = cfg.pad_enable ? 3'd4 : 3'd2;
        // (4 = char, flush, one pad; stored as 3 chars below)
      end
      2'd2: begin
        s0 = {leftover_bits, item.data_byte[7:6]};
        s1 = item.data_byte[5:0];
        leftover_bits_next = '0;
        byte_phase_next = 2'd0;
        n_chars = 3'd2;
      end
      default: begin  // phase 0, and the unused phase 3
        s0 = item.data_byte[7:2];
        s1 = {item.data_byte[1:0], 4'b0000};
        if (item.end_of_message) n_chars = cfg.pad_enable ? 3'd4 : 3'd2;
      end
    endcase
    if (item.end_of_message) begin
      byte_phase_next = '0;
      leftover_bits_next = '0;
    end
    op_new.chars[0] = sextet_char(s0, cfg.url_alphabet);
    op_new.chars[1] = sextet_char(s1, cfg.url_alphabet);
    op_new.chars[2] = CH_EQ;
    op_new.chars[3] = CH_EQ;
    op_new.last     = item.end_of_message;
    // phase 1 with padding gives three characters, not four
    if (byte_phase == 2'd1 && item.end_of_message && cfg.pad_enable) begin
      op_new.last_idx = 2'd2;
    end else begin
      op_new.last_idx = 2'(n_chars - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= '0;
      leftover_bits <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (accept) begin
        byte_phase    <= byte_phase_next;
        leftover_bits <= leftover_bits_next;
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (op_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(accept) - QCNT_W'(op_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) q[wr_ptr] <= op_new;
  end

endmodule

`default_nettype wire

/* hw/rtl/b64lw_back.sv */
// ----------------------------------------------------------------------------
// b64lw_back
// Walks the queued characters one per cycle while the result queue has
// room, inserts newlines at the line width and feeds the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64lw_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire b64lw_pkg::cfg_t cfg,
  input  wire logic            op_valid,
  input  wire b64lw_pkg::op_t  op_head,
  output logic                 op_pop,
  output logic                 empty,
  input  wire logic            pop,
  output b64lw_pkg::out_t      result
);
  import b64lw_pkg::*;

  logic [1:0]        k;
  logic              nl_pending;
  logic [7:0]        col;
  logic [7:0]        col_inc;
  logic              wrap, at_end, fin, emit, out_full;
  out_t              entry;

  out_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign out_full = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign result   = q[rd_ptr];

  always_comb begin
    emit    = op_valid && !out_full;
    col_inc = col + 8'd1;
    wrap    = (cfg.line_width != '0) && (col_inc >= cfg.line_width);
    at_end  = (k == op_head.last_idx);
    if (nl_pending) begin
      entry.char_code = CH_NL;
      fin = at_end;
    end else begin
      entry.char_code = op_head.chars[k];
      fin = at_end && !wrap;
    end
    entry.run_last    = fin;
    entry.message_end = fin && op_head.last;
    op_pop = emit && fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k          <= '0;
      nl_pending <= 1'b0;
      col        <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (emit) begin
        if (nl_pending) begin
          nl_pending <= 1'b0;
        end else if (wrap) begin
          nl_pending <= 1'b1;
        end
        if (nl_pending || !wrap) begin
          k <= at_end ? '0 : k + 2'd1;
        end
        if (op_pop && op_head.last) begin
          col <= '0;
        end else if (!nl_pending) begin
          col <= (wrap || cfg.line_width == '0) ? '0 : col_inc;
        end
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(emit) - QCNT_W'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) q[wr_ptr] <= entry;
  end

endmodule

`default_nettype wire

/* hw/rtl/base64_encoder_line_wrap.sv */
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// Streaming base64 encoder with URL-safe option, padding and line wrap.
// ----------------------------------------------------------------------------
// Usage:
//  - Input queue side: present item (data_byte, end_of_message) with push;
//    a request is taken on a clock edge where push is high and full is low.
//  - Result queue side: while empty is low the oldest character is on
//    result; it is taken on an edge where pop is high.
//  - Config: cfg_valid/cfg_ready with cfg_index (0 url_alphabet,
//    1 pad_enable, 2 line_width) and cfg_data; index 3 is ignored.
//    cfg_ready is always high. Write only while the encoder is idle.
//  - Path: the first character of a request goes through the request
//    queue and then the result queue before it appears on result.
//  - Throughput: the back end emits one character per cycle while the
//    result queue has room; a request causes 1 to 8 characters, newlines
//    included, and a steady stream gives four characters per three bytes
//    with no wrap, each newline taking an emit slot of its own.
//  - A two-entry request queue and a two-entry result queue let input
//    and output stall independently; full rises when the request queue
//    fills, which with pop low happens at the latest once both queues fill.
//  - Reset (rst, synchronous): group phase, line column and both queues
//    cleared; url_alphabet 0, pad_enable 1, line_width 0.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_encoder_line_wrap (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire b64lw_pkg::in_t   item,
  output logic                  empty,
  input  wire logic             pop,
  output b64lw_pkg::out_t       result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_data
);
  import b64lw_pkg::*;

  cfg_t cfg;
  logic op_valid, op_pop;
  op_t  op_head;

  assign cfg_ready = 1'b1;

  // config registers, written one at a time by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.url_alphabet <= 1'b0;
      cfg.pad_enable   <= 1'b1;
      cfg.line_width   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_URL:   cfg.url_alphabet <= cfg_data[0];
        CFG_PAD:   cfg.pad_enable   <= cfg_data[0];
        CFG_WIDTH: cfg.line_width   <= cfg_data;
        default: ;  // unused index
      endcase
    end
  end

  // front: phase tracking and character build
  b64lw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .item     (item),
    .op_valid (op_valid),
    .op_head  (op_head),
    .op_pop   (op_pop)
  );

  // back: per-character emit with newline insertion
  b64lw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op_valid (op_valid),
    .op_head  (op_head),
    .op_pop   (op_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  // checks
  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.message_end) |-> result.run_last)
    else $error("message end without run end");

  a_pop_needs_op: assert property (@(posedge clk) disable iff (rst)
    op_pop |-> op_valid)
    else $error("back popped an empty request queue");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !op_pop) |=> (op_valid && $stable(op_head)))
    else $error("request head changed before it was consumed");

endmodule

`default_nettype wire

/* test/b64lw_score_pkg.sv */
// ----------------------------------------------------------------------------
// b64lw_score_pkg
// Character scoreboard for the base64 line-wrap encoder: it predicts the
// characters of each accepted request and checks the popped results.
// ----------------------------------------------------------------------------
package b64lw_score_pkg;

  import b64lw_pkg::*;

  class char_scoreboard;

    // shadow of the configuration registers
    logic       url_alpha;
    logic       pad_on;
    logic [7:0] wrap_width;

    // encoder state
    logic [1:0] grp_phase;
    logic [3:0] rem_bits;
    logic [7:0] column;

    out_t pending[$];
    out_t step_chars[$];
    int   faults;

    function new();
      url_alpha  = 1'b0;
      pad_on     = 1'b1;
      wrap_width = 8'd0;
      grp_phase  = 2'd0;
      rem_bits   = 4'd0;
      column     = 8'd0;
      faults     = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_URL:   url_alpha  = val[0];
        CFG_PAD:   pad_on     = val[0];
        CFG_WIDTH: wrap_width = val;
        default:   ;
      endcase
    endfunction

    function logic [7:0] map_sextet(logic [5:0] v);
      logic [7:0] c;
      if (v <= 6'd25) c = CH_UPPER_A + {2'b00, v};
      else if (v <= 6'd51) c = CH_LOWER_A + ({2'b00, v} - 8'd26);
      else if (v <= 6'd61) c = CH_ZERO + ({2'b00, v} - 8'd52);
      else if (v == 6'd62) c = url_alpha ? CH_DASH : CH_PLUS;
      else c = url_alpha ? CH_UNDER : CH_SLASH;
      return c;
    endfunction

    // one line character, plus a newline once the line is full
    function void add_char(logic [7:0] c);
      out_t r;
      r.char_code   = c;
      r.run_last    = 1'b0;
      r.message_end = 1'b0;
      step_chars.push_back(r);
      if (wrap_width == 8'd0) begin
        column = 8'd0;
      end else begin
        column = column + 8'd1;
        if (column >= wrap_width) begin
          r.char_code = CH_NL;
          step_chars.push_back(r);
          column = 8'd0;
        end
      end
    endfunction

    function void note_byte(in_t it);
      logic [7:0] d;
      int         pads;
      out_t       tail;
      d    = it.data_byte;
      pads = 0;
      step_chars.delete();
      case (grp_phase)
        2'd1: begin
          add_char(map_sextet({rem_bits[1:0], d[7:4]}));
          rem_bits  = d[3:0];
          grp_phase = 2'd2;
        end
        2'd2: begin
          add_char(map_sextet({rem_bits, d[7:6]}));
          add_char(map_sextet(d[5:0]));
          rem_bits  = 4'd0;
          grp_phase = 2'd0;
        end
        default: begin
          add_char(map_sextet(d[7:2]));
          rem_bits  = {2'b00, d[1:0]};
          grp_phase = 2'd1;
        end
      endcase
      if (it.end_of_message) begin
        if (grp_phase == 2'd1) begin
          add_char(map_sextet({rem_bits[1:0], 4'b0000}));
          pads = 2;
        end else if (grp_phase == 2'd2) begin
          add_char(map_sextet({rem_bits, 2'b00}));
          pads = 1;
        end
        if (pad_on) begin
          repeat (pads) add_char(CH_EQ);
        end
        grp_phase = 2'd0;
        rem_bits  = 4'd0;
        column    = 8'd0;
      end
      tail             = step_chars.pop_back();
      tail.run_last    = 1'b1;
      tail.message_end = it.end_of_message;
      step_chars.push_back(tail);
      foreach (step_chars[i]) pending.push_back(step_chars[i]);
    endfunction

    function void fault(string what, out_t want, out_t got);
      faults++;
      if (faults <= 10) begin
        $display("mismatch (%s): exp char %h last %b end %b, got char %h last %b end %b",
                 what, want.char_code, want.run_last, want.message_end,
                 got.char_code, got.run_last, got.message_end);
      end
    endfunction

    function void check_char(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        want = '0;
        fault("no character due", want, got);
        return;
      end
      want = pending.pop_front();
      if (got.char_code !== want.char_code) fault("char_code", want, got);
      else if (got.run_last !== want.run_last) fault("run_last", want, got);
      else if (got.message_end !== want.message_end) fault("message_end", want, got);
    endfunction

    // characters still owed at the end of the run
    function void close_out();
      out_t none;
      none = '0;
      while (pending.size() != 0) fault("never popped", pending.pop_front(), none);
    endfunction

  endclass

endpackage

/* test/tb_base64_encoder_line_wrap.sv */
// ----------------------------------------------------------------------------
// tb_base64_encoder_line_wrap
// Self-checking bench for the base64 line-wrap encoder: directed messages
// for alphabet, padding and wrap corners, then random messages over several
// idle/stall phases and register settings, checked character by character.
// ----------------------------------------------------------------------------
module tb_base64_encoder_line_wrap;

  timeunit 1ns;
  timeprecision 1ps;

  import b64lw_pkg::*;
  import b64lw_score_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // unused index, write ignored
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 10;          // cycles after the last character

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  in_t        item;
  logic       empty;
  logic       pop;
  out_t       result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  char_scoreboard sb;

  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_cycles;  // long receiver hold-off, counted down by the receiver
  int cycles;

  base64_encoder_line_wrap dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL base64_encoder_line_wrap");
    $finish;
  end

  // Monitor: every accepted request, result and register write is seen here,
  // using values sampled before this edge's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (push && !full) sb.note_byte(item);
      if (pop && !empty) sb.check_char(result);
    end
  end

  // Receiver: random stalls, or a solid hold-off while rx_hold_cycles runs down.
  initial begin
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        pop <= 1'b0;
        rx_hold_cycles--;
      end else begin
        pop <= ($urandom_range(99) >= rx_stall_pct);
      end
      @(posedge clk);
    end
  end

  // Offer one byte; returns at the edge where the request was taken.
  task automatic send_byte(input logic [7:0] d, input logic eom);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push                <= 1'b1;
    item.data_byte      <= d;
    item.end_of_message <= eom;
    do @(posedge clk); while (full);
  endtask

  // Let every owed character come out, then wait out SETTLE before touching
  // the registers. The first wait makes sure the monitor has noted the last
  // accepted request.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all three registers back to back; the spare index is optional.
  task automatic program_cfg(input logic url, input logic pad, input logic [7:0] width,
                             input bit with_spare);
    logic [1:0] idx[4];
    logic [7:0] val[4];
    int         n;
    idx[0] = CFG_URL;   val[0] = {7'd0, url};
    idx[1] = CFG_PAD;   val[1] = {7'd0, pad};
    idx[2] = CFG_WIDTH; val[2] = width;
    idx[3] = CFG_SPARE; val[3] = 8'($urandom_range(255));
    n = with_spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_width();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(12, 1));
  endfunction

  // Random messages; the phase budget may cut the last one short so that the
  // next register write lands mid message.
  task automatic random_messages(input int budget);
    int left;
    int len;
    int n;
    left = budget;
    while (left > 0) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
      n   = (len < left) ? len : left;
      for (int i = 0; i < n; i++) begin
        send_byte(8'($urandom_range(255)), (i == len - 1));
      end
      left -= n;
    end
  endtask

  initial begin
    int mode;
    sb             = new();
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = 0;
    rst       <= 1'b1;
    push      <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_URL;
    cfg_data  <= 8'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed: reset settings (standard alphabet, padding, no wrap)
    send_byte(8'h00, 1'b1);                         // one byte, two pads
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1); // two bytes, one pad, '/'
    send_byte(8'hFB, 1'b0); send_byte(8'hEF, 1'b0); // all sextets 62: '+'
    send_byte(8'hBE, 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); // full group then a tail
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b1);
    drain();

    // URL alphabet, no padding, four-character lines: full last line gets
    // a trailing newline
    program_cfg(1'b1, 1'b0, 8'd4, 1'b0);
    send_byte(8'hFB, 1'b0); send_byte(8'hEF, 1'b0); send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b1);                         // '_' and no pads
    drain();

    // leave a message open at column five, then narrow the line under it
    program_cfg(1'b1, 1'b0, 8'd8, 1'b0);
    send_byte(8'h12, 1'b0); send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0); send_byte(8'h78, 1'b0);
    drain();
    program_cfg(1'b0, 1'b1, 8'd2, 1'b1);
    send_byte(8'h9A, 1'b1);
    drain();

    // width of one: newline after every character, pads included
    program_cfg(1'b0, 1'b1, 8'd1, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();
    program_cfg(1'b1, 1'b1, 8'd255, 1'b0);
    send_byte(8'hFC, 1'b1);
    drain();

    // ---- random phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       program_cfg(1'b0, 1'b1, 8'd0, 1'b0);
        1:       program_cfg(1'b1, 1'b0, 8'd1, 1'b0);
        2:       program_cfg(1'b0, 1'b1, 8'd255, 1'b1);
        default: program_cfg(1'($urandom_range(1)), 1'($urandom_range(1)), pick_width(),
                             1'b0);
      endcase
      mode = ph % 4;
      tx_idle_pct  = (mode == 1) ? 60 : (mode == 3) ? 18 : 0;
      rx_stall_pct = (mode == 2) ? 60 : (mode == 3) ? 18 : 0;
      // first phase: receiver holds off while the sender keeps offering,
      // so both queues fill and full stalls the input
      if (ph == 0) rx_hold_cycles = 300;
      random_messages(45);
      drain();
    end

    // drain() has already waited out the settle time
    sb.close_out();
    if (sb.faults == 0) begin
      $display("PASS base64_encoder_line_wrap");
    end else begin
      $display("FAIL base64_encoder_line_wrap");
    end
    $finish;
  end

endmodule
